/* rtl/bre_pkg.sv */
// Shared constants, types and codes of the breathing rate estimator.
`default_nettype none
package bre_pkg;

  localparam int WINDOW_LEN     = 100;
  localparam int CROSSING_SLOTS = 10;
  localparam int MIN_CROSSINGS  = 3;
  localparam int SAMPLE_BITS    = 18;

  localparam int PTR_W   = $clog2(WINDOW_LEN);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_LEN + 1);
  localparam int HEAD_W  = $clog2(CROSSING_SLOTS);
  localparam int CNT_W   = $clog2(CROSSING_SLOTS + 1);
  localparam int TIME_W  = 32;
  localparam int MS_PER_MIN = 60000;
  localparam int NUM_W   = CNT_W + 16;
  localparam int S_W     = TIME_W + CNT_W;
  localparam int HALF_W  = (S_W + 1) / 2;
  localparam int SQ_W    = 2 * TIME_W + CNT_W;
  localparam int V_W     = 2 * S_W;
  localparam int Q_SHIFT = 30;
  localparam int W_W     = V_W + Q_SHIFT;
  localparam int SPAN_P_W = TIME_W + 8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_THRES = 2'd2;

  localparam logic [7:0]  RATE_MIN_RST  = 8'd10;
  localparam logic [7:0]  RATE_MAX_RST  = 8'd100;
  localparam logic [15:0] REG_THRES_RST = 16'd19661;
  localparam logic [15:0] Q15_ONE       = 16'd32768;

  typedef struct packed {
    logic [17:0]       ir_sample;
    logic              finger_present;
    logic [TIME_W-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic        breath_valid;
    logic [7:0]  breaths_per_min;
    logic [15:0] regularity;
    logic        breath_regular;
  } out_item_t;

  typedef struct packed {
    logic              above;
    logic              finger;
    logic [TIME_W-1:0] time_ms;
  } cls_t;

  typedef struct packed {
    logic [7:0]  rate_min;
    logic [7:0]  rate_max;
    logic [15:0] regular_threshold;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/bre_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/bre_front.sv */
// Front end: takes items, updates the sample window and classifies against the mean.
`default_nettype none
module bre_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bre_pkg::in_item_t in_item_i,
  output logic                   full_o,
  output logic                   mid_valid_o,
  output bre_pkg::cls_t          mid_data_o,
  input  wire logic              mid_pop_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_READ = 2'd1;
  localparam logic [1:0] F_CLS  = 2'd2;

  logic [1:0]                      state_q;
  bre_pkg::in_item_t               item_q;
  logic [bre_pkg::PTR_W-1:0]       ptr_q;
  logic                            wrapped_q;
  logic [bre_pkg::SUM_W-1:0]       sum_q;
  logic [bre_pkg::SAMPLE_BITS-1:0] rdata;
  logic [bre_pkg::SAMPLE_BITS-1:0] sample;
  logic [bre_pkg::SAMPLE_BITS-1:0] old_sample;
  logic                            above;
  logic                            we;
  logic                            fifo_push;
  bre_pkg::cls_t                   fifo_q [2];
  logic                            wr_q, rd_q;
  logic [1:0]                      cnt_q;

  assign sample     = item_q.ir_sample[bre_pkg::SAMPLE_BITS-1:0];
  // Slots not yet written since reset read as zero.
  assign old_sample = wrapped_q ? rdata : '0;
  assign we         = (state_q == F_READ);
  assign above      = (bre_pkg::SUM_W'(sample) * bre_pkg::SUM_W'(bre_pkg::WINDOW_LEN)) >= sum_q;
  assign fifo_push  = (state_q == F_CLS) && (cnt_q != 2'd2);
  assign full_o     = (state_q != F_IDLE);

  bre_ram #(
    .WIDTH(bre_pkg::SAMPLE_BITS),
    .DEPTH(bre_pkg::WINDOW_LEN)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(ptr_q),
    .wdata_i(sample),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
      sum_q     <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (push_i) begin
            item_q  <= in_item_i;
            state_q <= F_READ;
          end
        end
        F_READ: begin
          sum_q <= sum_q - bre_pkg::SUM_W'(old_sample) + bre_pkg::SUM_W'(sample);
          if (ptr_q == bre_pkg::PTR_W'(bre_pkg::WINDOW_LEN - 1)) begin
            ptr_q     <= '0;
            wrapped_q <= 1'b1;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
          state_q <= F_CLS;
        end
        F_CLS: begin
          if (fifo_push) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // Two-entry queue toward the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (fifo_push) begin
        fifo_q[wr_q] <= '{above: above, finger: item_q.finger_present,
                          time_ms: item_q.time_ms};
        wr_q <= ~wr_q;
      end
      if (mid_pop_i && (cnt_q != 2'd0)) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, fifo_push} - {1'b0, mid_pop_i && (cnt_q != 2'd0)};
    end
  end

  assign mid_valid_o = (cnt_q != 2'd0);
  assign mid_data_o  = fifo_q[rd_q];

endmodule
`default_nettype wire

/* rtl/bre_back.sv */
// Back end: crossing log, rate division, regularity search and result queue.
`default_nettype none
module bre_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bre_pkg::cfg_t  cfg_i,
  input  wire logic           mid_valid_i,
  input  wire bre_pkg::cls_t  mid_data_i,
  output logic                mid_pop_o,
  output logic                empty_o,
  output bre_pkg::out_item_t  out_item_o,
  input  wire logic           pop_i
);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_CROSS = 4'd1;
  localparam logic [3:0] B_OLD   = 4'd2;
  localparam logic [3:0] B_NEW   = 4'd3;
  localparam logic [3:0] B_RANGE = 4'd4;
  localparam logic [3:0] B_DIV   = 4'd5;
  localparam logic [3:0] B_INT   = 4'd6;
  localparam logic [3:0] B_SQ1   = 4'd7;
  localparam logic [3:0] B_SQ2   = 4'd8;
  localparam logic [3:0] B_VAR   = 4'd9;
  localparam logic [3:0] B_SRCH  = 4'd10;
  localparam logic [3:0] B_DONE  = 4'd11;
  localparam logic [3:0] B_EMIT  = 4'd12;

  localparam int HW = bre_pkg::HEAD_W;
  localparam int TW = bre_pkg::TIME_W;

  logic [3:0]                  st_q;
  logic                        was_below_q;
  logic [TW-1:0]               times_q [bre_pkg::CROSSING_SLOTS];
  logic [HW-1:0]               head_q, first_q, idx_q, rd_idx, idx_next;
  logic [bre_pkg::CNT_W-1:0]   count_q, i_q, n;
  bre_pkg::out_item_t          held_q;
  logic [TW-1:0]               oldest_q, prev_q, span_q, rd_time, x, span_d;
  logic [bre_pkg::NUM_W-1:0]   num_q, rem_q;
  logic [7:0]                  quot_q;
  logic [3:0]                  bit_q;
  logic [bre_pkg::S_W-1:0]     s_q;
  logic [bre_pkg::SQ_W-1:0]    sumsq_q;
  logic [bre_pkg::V_W-1:0]     s2_q, nsq;
  logic [bre_pkg::W_W-1:0]     w_q, p_q, qq_q;
  logic [bre_pkg::W_W:0]       cand;
  logic [14:0]                 m_q;
  logic [HW:0]                 ftmp;
  logic [bre_pkg::SPAN_P_W-1:0] lo_lim, hi_lim, dsub;
  logic [15:0]                 reg_val;
  logic                        ofull, opush;
  bre_pkg::out_item_t          ofifo_q [2];
  logic                        owr_q, ord_q;
  logic [1:0]                  ocnt_q;

  assign n        = count_q - 1'b1;
  assign rd_idx   = (st_q == B_OLD) ? first_q :
                    (st_q == B_NEW) ? ((head_q == '0) ? HW'(bre_pkg::CROSSING_SLOTS - 1)
                                                      : head_q - 1'b1) : idx_q;
  assign rd_time  = times_q[rd_idx];
  assign idx_next = (idx_q == HW'(bre_pkg::CROSSING_SLOTS - 1)) ? '0 : idx_q + 1'b1;
  assign x        = rd_time - prev_q;
  assign span_d   = rd_time - oldest_q;
  assign ftmp     = {1'b0, head_q} + (HW+1)'(bre_pkg::CROSSING_SLOTS) - (HW+1)'(count_q);
  assign lo_lim   = bre_pkg::SPAN_P_W'(cfg_i.rate_min) * bre_pkg::SPAN_P_W'(span_q);
  assign hi_lim   = bre_pkg::SPAN_P_W'(cfg_i.rate_max) * bre_pkg::SPAN_P_W'(span_q);
  assign dsub     = bre_pkg::SPAN_P_W'(span_q) << bit_q;
  assign nsq      = bre_pkg::V_W'(n) * bre_pkg::V_W'(sumsq_q);
  assign cand     = (bre_pkg::W_W+1)'(p_q) + ((bre_pkg::W_W+1)'(qq_q) << (bit_q + 4'd1))
                    + ((bre_pkg::W_W+1)'(s2_q) << {bit_q, 1'b0});
  assign reg_val  = (w_q == '0) ? bre_pkg::Q15_ONE : 16'd32767 - {1'b0, m_q};
  assign ofull    = (ocnt_q == 2'd2);
  assign opush    = (st_q == B_EMIT) && !ofull;
  assign mid_pop_o = (st_q == B_IDLE) && mid_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      was_below_q <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      held_q      <= '0;
      for (int k = 0; k < bre_pkg::CROSSING_SLOTS; k++) begin
        times_q[k] <= '0;
      end
    end else begin
      case (st_q)
        B_IDLE: begin
          if (mid_valid_i) begin
            if (!mid_data_i.finger) begin
              held_q.breath_valid <= 1'b0;
              st_q                <= B_EMIT;
            end else begin
              if (was_below_q && mid_data_i.above) begin
                times_q[head_q] <= mid_data_i.time_ms;
                head_q <= (head_q == HW'(bre_pkg::CROSSING_SLOTS - 1)) ? '0 : head_q + 1'b1;
                if (count_q < bre_pkg::CNT_W'(bre_pkg::CROSSING_SLOTS)) begin
                  count_q <= count_q + 1'b1;
                end
              end
              was_below_q <= !mid_data_i.above;
              st_q        <= B_CROSS;
            end
          end
        end
        B_CROSS: begin
          if (count_q < bre_pkg::CNT_W'(bre_pkg::MIN_CROSSINGS)) begin
            held_q.breath_valid <= 1'b0;
            st_q                <= B_EMIT;
          end else begin
            first_q <= (ftmp >= (HW+1)'(bre_pkg::CROSSING_SLOTS))
                       ? HW'(ftmp - (HW+1)'(bre_pkg::CROSSING_SLOTS)) : HW'(ftmp);
            st_q    <= B_OLD;
          end
        end
        B_OLD: begin
          oldest_q <= rd_time;
          st_q     <= B_NEW;
        end
        B_NEW: begin
          span_q <= span_d;
          num_q  <= bre_pkg::NUM_W'(n) * bre_pkg::NUM_W'(bre_pkg::MS_PER_MIN);
          st_q   <= (span_d == '0) ? B_EMIT : B_RANGE;
        end
        B_RANGE: begin
          if ((bre_pkg::SPAN_P_W'(num_q) < lo_lim) || (bre_pkg::SPAN_P_W'(num_q) > hi_lim)) begin
            st_q <= B_EMIT;
          end else begin
            rem_q  <= num_q;
            quot_q <= '0;
            bit_q  <= 4'd7;
            st_q   <= B_DIV;
          end
        end
        B_DIV: begin
          // Restoring division; the range check bounds the quotient to 8 bits.
          if (bre_pkg::SPAN_P_W'(rem_q) >= dsub) begin
            rem_q          <= bre_pkg::NUM_W'(bre_pkg::SPAN_P_W'(rem_q) - dsub);
            quot_q[bit_q[2:0]] <= 1'b1;
          end
          if (bit_q == 4'd0) begin
            idx_q   <= (first_q == HW'(bre_pkg::CROSSING_SLOTS - 1)) ? '0 : first_q + 1'b1;
            prev_q  <= oldest_q;
            i_q     <= '0;
            s_q     <= '0;
            sumsq_q <= '0;
            st_q    <= B_INT;
          end else begin
            bit_q <= bit_q - 4'd1;
          end
        end
        B_INT: begin
          s_q     <= s_q + bre_pkg::S_W'(x);
          sumsq_q <= sumsq_q + bre_pkg::SQ_W'((2*TW)'(x) * (2*TW)'(x));
          prev_q  <= rd_time;
          idx_q   <= idx_next;
          i_q     <= i_q + 1'b1;
          if (i_q == n - 1'b1) begin
            st_q <= B_SQ1;
          end
        end
        B_SQ1: begin
          s2_q <= bre_pkg::V_W'(s_q) * bre_pkg::V_W'(s_q[bre_pkg::HALF_W-1:0]);
          st_q <= B_SQ2;
        end
        B_SQ2: begin
          s2_q <= s2_q + ((bre_pkg::V_W'(s_q) *
                  bre_pkg::V_W'(s_q[bre_pkg::S_W-1:bre_pkg::HALF_W])) << bre_pkg::HALF_W);
          st_q <= B_VAR;
        end
        B_VAR: begin
          w_q   <= {nsq - s2_q, {bre_pkg::Q_SHIFT{1'b0}}};
          p_q   <= '0;
          qq_q  <= '0;
          m_q   <= '0;
          bit_q <= 4'd14;
          st_q  <= B_SRCH;
        end
        B_SRCH: begin
          // Largest m with m*m*S^2 below the scaled variance, one bit per cycle.
          if (cand < (bre_pkg::W_W+1)'(w_q)) begin
            p_q        <= bre_pkg::W_W'(cand);
            qq_q       <= qq_q + (bre_pkg::W_W'(s2_q) << bit_q);
            m_q[bit_q] <= 1'b1;
          end
          if (bit_q == 4'd0) begin
            st_q <= B_DONE;
          end else begin
            bit_q <= bit_q - 4'd1;
          end
        end
        B_DONE: begin
          held_q <= '{breath_valid: 1'b1, breaths_per_min: quot_q, regularity: reg_val,
                      breath_regular: (reg_val > cfg_i.regular_threshold)};
          st_q   <= B_EMIT;
        end
        B_EMIT: begin
          if (!ofull) begin
            st_q <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (opush) begin
        ofifo_q[owr_q] <= held_q;
        owr_q          <= ~owr_q;
      end
      if (pop_i && (ocnt_q != 2'd0)) begin
        ord_q <= ~ord_q;
      end
      ocnt_q <= ocnt_q + {1'b0, opush} - {1'b0, pop_i && (ocnt_q != 2'd0)};
    end
  end

  assign empty_o    = (ocnt_q == 2'd0);
  assign out_item_o = ofifo_q[ord_q];

endmodule
`default_nettype wire

/* rtl/breathing_rate_estimator.sv */
// Top level of the breathing rate estimator: configuration registers and the two halves.
//
// Usage: each item pushed on the input queue interface (push_i, full_o) carries one
// infrared sample, a finger-present flag and a millisecond time stamp. Every item
// yields exactly one result item on the output queue interface (empty_o, pop_i):
// the current breath_valid flag together with the held rate, regularity and flag.
// The front end takes one item at a time: the accepting cycle reads the old window
// sample, the next one updates the running sum, and the state after that classifies
// the sample against the mean and hands it to a two-entry queue, waiting while it is full.
// The back end goes straight to its result when no finger is present or with too few
// crossings; a full estimate runs an 8-step restoring divider for the rate, sums one
// interval per cycle, squares the interval sum from its two halves and runs a 15-step
// regularity search.
// Configuration (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) is always
// ready and must only be written while no item is in flight.
// Reset clears the sample window (through a wrap flag, so no clearing pass is
// needed), the crossing log and the held outputs. When the receiver stalls, the
// two-entry result queue fills, the back end waits, then the middle queue and
// finally the front end fill and full_o stays high.
`default_nettype none
module breathing_rate_estimator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  input  wire bre_pkg::in_item_t                 in_item_i,
  output logic                                   full_o,
  output logic                                   empty_o,
  output bre_pkg::out_item_t                     out_item_o,
  input  wire logic                              pop_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bre_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [15:0]                       cfg_data_i
);

  bre_pkg::cfg_t cfg_q;
  logic          mid_valid;
  logic          mid_pop;
  bre_pkg::cls_t mid_data;

  assign cfg_ready_o = 1'b1;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rate_min: bre_pkg::RATE_MIN_RST, rate_max: bre_pkg::RATE_MAX_RST,
                 regular_threshold: bre_pkg::REG_THRES_RST};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bre_pkg::CFG_RATE_MIN:  cfg_q.rate_min          <= cfg_data_i[7:0];
        bre_pkg::CFG_RATE_MAX:  cfg_q.rate_max          <= cfg_data_i[7:0];
        bre_pkg::CFG_REG_THRES: cfg_q.regular_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bre_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_item_i  (in_item_i),
    .full_o     (full_o),
    .mid_valid_o(mid_valid),
    .mid_data_o (mid_data),
    .mid_pop_i  (mid_pop)
  );

  bre_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .mid_valid_i(mid_valid),
    .mid_data_i (mid_data),
    .mid_pop_o  (mid_pop),
    .empty_o    (empty_o),
    .out_item_o (out_item_o),
    .pop_i      (pop_i)
  );

  // An accepted item keeps the front end busy for the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |=> full_o)
    else $error("front end took a second item back to back");

  // The back end only takes from the middle queue when it holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> mid_valid)
    else $error("middle queue popped while empty");

  // A waiting result never carries a regularity above one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (out_item_o.regularity <= bre_pkg::Q15_ONE))
    else $error("regularity out of range");

endmodule
`default_nettype wire
